// ----- rtl/tht_pkg.sv -----
// Shared types, request codes and sizes for the target health table.
package tht_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int EXP_W = 34;
  localparam int META_W = 25;

  localparam logic [2:0] REQ_BLACKLIST = 3'd0;
  localparam logic [2:0] REQ_QUERY = 3'd1;
  localparam logic [2:0] REQ_SUCCESS = 3'd2;
  localparam logic [2:0] REQ_PROBE = 3'd3;
  localparam logic [2:0] REQ_UNTESTED = 3'd4;
  localparam logic [2:0] REQ_CLEAR = 3'd5;

  localparam logic [1:0] ST_WHITE = 2'd0;
  localparam logic [1:0] ST_GRAY_IDLE = 2'd1;
  localparam logic [1:0] ST_GRAY_PROBING = 2'd2;
  localparam logic [1:0] ST_BLACK = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic        addr_family;
    logic [15:0] port_number;
    logic [7:0]  transport_proto;
    logic [31:0] now_seconds;
    logic [15:0] blacklist_seconds;
    logic [15:0] graylist_seconds;
    logic [7:0]  prober_id;
  } req_t;

  typedef struct packed {
    logic [1:0] host_status;
    logic       entry_found;
    logic       table_full;
  } rsp_t;

  // Classified request as passed from the front to the back.
  typedef struct packed {
    logic [2:0]        op;
    logic [63:0]       hi;
    logic [63:0]       lo;
    logic [META_W-1:0] meta;
    logic [31:0]       now;
    logic [EXP_W-1:0]  black_exp;
    logic [EXP_W-1:0]  gray_exp;
    logic [7:0]        who;
  } cmd_t;

endpackage

// ----- rtl/tht_front.sv -----
// Front end: accepts requests, builds the normalized key and expiries, queues them.
module tht_front (
  input  logic           clk,
  input  logic           rst,
  input  tht_pkg::req_t  req,
  input  logic           valid,
  output logic           stall,
  output tht_pkg::cmd_t  cmd,
  output logic           cmd_valid,
  input  logic           cmd_take
);
  import tht_pkg::*;

  cmd_t q [2];
  logic [1:0] cnt;
  logic rd_ptr, wr_ptr;
  cmd_t c;
  logic push, pop;

  // Normalize the key: IPv4 keeps only the low 32 address bits.
  always_comb begin
    c.op = req.req_type;
    c.hi = req.addr_family ? req.addr_hi : 64'd0;
    c.lo = req.addr_family ? req.addr_lo : {32'd0, req.addr_lo[31:0]};
    c.meta = {req.addr_family, req.port_number, req.transport_proto};
    c.now = req.now_seconds;
    c.black_exp = {2'b00, req.now_seconds} + {18'd0, req.blacklist_seconds};
    c.gray_exp = {2'b00, req.now_seconds} + {18'd0, req.blacklist_seconds}
               + {18'd0, req.graylist_seconds};
    c.who = req.prober_id;
  end

  assign stall = (cnt == 2'd2);
  assign push = valid && !stall;
  assign pop = cmd_valid && cmd_take;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = q[rd_ptr];

  // Two-entry queue toward the back end.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        q[wr_ptr] <= c;
        wr_ptr <= ~wr_ptr;
      end
      if (pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- rtl/tht_back.sv -----
// Back end: scans the table one entry a cycle, then applies the request.
module tht_back (
  input  logic           clk,
  input  logic           rst,
  input  tht_pkg::cmd_t  cmd,
  input  logic           cmd_valid,
  output logic           cmd_take,
  output tht_pkg::rsp_t  rsp,
  output logic           rsp_valid,
  input  logic           rsp_stall
);
  import tht_pkg::*;

  typedef enum logic [1:0] {IDLE, SCAN, APPLY} state_t;

  state_t state;
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [63:0]        key_hi [TABLE_ENTRIES];
  logic [63:0]        key_lo [TABLE_ENTRIES];
  logic [META_W-1:0]  key_meta [TABLE_ENTRIES];
  logic [EXP_W-1:0]   black_expiry [TABLE_ENTRIES];
  logic [EXP_W-1:0]   gray_expiry [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] probing_flag;
  logic [7:0]         prober_owner [TABLE_ENTRIES];

  cmd_t cur;
  logic [CNT_W-1:0] scan;
  logic hit, free_seen;
  logic [IDX_W-1:0] hit_idx, free_idx;
  logic match;
  logic [IDX_W-1:0] s;
  logic [1:0] st;
  rsp_t rsp_next;

  assign cmd_take = (state == IDLE) && cmd_valid && !(rsp_valid && rsp_stall);

  // Compare the entry under the scan pointer with the request key.
  always_comb begin
    match = entry_valid[scan[IDX_W-1:0]] && key_hi[scan[IDX_W-1:0]] == cur.hi
         && key_lo[scan[IDX_W-1:0]] == cur.lo && key_meta[scan[IDX_W-1:0]] == cur.meta;
  end

  // Health of the hit entry at the request time.
  always_comb begin
    if ({2'b00, cur.now} < black_expiry[hit_idx]) st = ST_BLACK;
    else if ({2'b00, cur.now} < gray_expiry[hit_idx])
      st = probing_flag[hit_idx] ? ST_GRAY_PROBING : ST_GRAY_IDLE;
    else st = ST_WHITE;
    s = hit ? hit_idx : free_idx;
  end

  // Response for the request once the scan is done.
  always_comb begin
    rsp_next = '0;
    case (cur.op)
      REQ_BLACKLIST: begin
        rsp_next.entry_found = hit;
        rsp_next.table_full = !hit && !free_seen;
      end
      REQ_QUERY: begin
        rsp_next.entry_found = hit;
        if (hit) rsp_next.host_status = st;
      end
      REQ_SUCCESS: rsp_next.entry_found = hit;
      REQ_PROBE: rsp_next.entry_found = hit;
      REQ_UNTESTED: rsp_next.entry_found = hit;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      entry_valid <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (cmd_take) begin
            cur <= cmd;
            scan <= '0;
            hit <= 1'b0;
            free_seen <= 1'b0;
            state <= SCAN;
          end
        end
        SCAN: begin
          if (match && !hit) begin
            hit <= 1'b1;
            hit_idx <= scan[IDX_W-1:0];
          end
          if (!entry_valid[scan[IDX_W-1:0]] && !free_seen) begin
            free_seen <= 1'b1;
            free_idx <= scan[IDX_W-1:0];
          end
          if (scan == CNT_W'(TABLE_ENTRIES - 1)) state <= APPLY;
          else scan <= scan + 1'b1;
        end
        APPLY: begin
          rsp <= rsp_next;
          rsp_valid <= 1'b1;
          state <= IDLE;
          case (cur.op)
            REQ_CLEAR: entry_valid <= '0;
            REQ_BLACKLIST: begin
              if (hit || free_seen) begin
                entry_valid[s] <= 1'b1;
                key_hi[s] <= cur.hi;
                key_lo[s] <= cur.lo;
                key_meta[s] <= cur.meta;
                black_expiry[s] <= cur.black_exp;
                gray_expiry[s] <= cur.gray_exp;
                probing_flag[s] <= 1'b0;
                prober_owner[s] <= 8'd0;
              end
            end
            REQ_QUERY: begin
              if (hit && st == ST_WHITE) entry_valid[hit_idx] <= 1'b0;
            end
            REQ_SUCCESS: begin
              if (hit && st != ST_BLACK) begin
                probing_flag[hit_idx] <= 1'b0;
                black_expiry[hit_idx] <= '0;
                gray_expiry[hit_idx] <= '0;
              end
            end
            REQ_PROBE: begin
              if (hit && st == ST_GRAY_IDLE) begin
                probing_flag[hit_idx] <= 1'b1;
                prober_owner[hit_idx] <= cur.who;
              end
            end
            REQ_UNTESTED: begin
              if (hit && st == ST_GRAY_PROBING && prober_owner[hit_idx] == cur.who)
                probing_flag[hit_idx] <= 1'b0;
            end
            default: ;
          endcase
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/target_health_table.sv -----
// Top level of the target health table: request queue front end and table back end.
// Each request passes through the back end in order: it is taken from the queue,
// a sequential scan of every entry looks for the key and a free slot, and then the
// entry is updated and the result registered. The back end takes a new request only
// once it is idle again and no result is held by an output stall. A two-deep request
// queue and the result register let the requester and the consumer stall
// independently; one result per request, in order.
module target_health_table (
  input  logic           clk,
  input  logic           rst,
  input  tht_pkg::req_t  req,
  input  logic           req_valid,
  output logic           req_stall,
  output tht_pkg::rsp_t  rsp,
  output logic           rsp_valid,
  input  logic           rsp_stall
);
  import tht_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_take;

  tht_front u_front (
    .clk, .rst, .req, .valid(req_valid), .stall(req_stall),
    .cmd, .cmd_valid, .cmd_take
  );

  tht_back u_back (
    .clk, .rst, .cmd, .cmd_valid, .cmd_take,
    .rsp, .rsp_valid, .rsp_stall
  );
endmodule
